/* rtl/core/abfdr_pkg.sv */
// Shared types, constants and helper functions for the ADC button conditioner.
package abfdr_pkg;

  localparam int ADC_BITS  = 10;
  localparam int MAX_SHIFT = 8;
  localparam int ACC_W     = ADC_BITS + MAX_SHIFT;
  localparam int ELAPSED_W = 20;
  localparam int SHIFT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [ADC_BITS-1:0]  LEVEL_FULL  = {ADC_BITS{1'b1}};
  localparam logic [ACC_W-1:0]     ACC_MAX     = {ACC_W{1'b1}};
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
  localparam logic [ACC_W-1:0]     ACC_RESET   = ACC_W'(LEVEL_FULL) << 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_PRESSED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_RELEASED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICK               = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SHIFT       = 3'd5;

  // Reported phase codes.
  localparam logic [1:0] CODE_UP       = 2'd0;
  localparam logic [1:0] CODE_DEBOUNCE = 2'd1;
  localparam logic [1:0] CODE_PRESSED  = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [2:0] {
    PH_UP       = 3'b001,
    PH_DEBOUNCE = 3'b010,
    PH_PRESSED  = 3'b100
  } phase_t;

  typedef struct packed {
    logic                req_type;
    logic [ADC_BITS-1:0] adc_sample;
  } in_t;

  typedef struct packed {
    logic                press_valid;
    logic [ADC_BITS-1:0] held_level;
    logic [ADC_BITS-1:0] filtered_level;
    logic [1:0]          fsm_state;
  } out_t;

  typedef struct packed {
    logic [9:0]  threshold_pressed;
    logic [9:0]  threshold_released;
    logic [19:0] repeat_delay_us;
    logic [16:0] debounce_delay_us;
    logic [9:0]  tick_us;
    logic [3:0]  filter_shift;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0]     integrator;
    phase_t               phase;
    logic [ELAPSED_W-1:0] elapsed_us;
    logic [ADC_BITS-1:0]  pressed_level;
    logic [ADC_BITS-1:0]  output_hold;
  } state_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_DEBOUNCE: code = CODE_DEBOUNCE;
      PH_PRESSED:  code = CODE_PRESSED;
      default:     code = CODE_UP;
    endcase
    return code;
  endfunction

  // Shift setting clamped into the supported range.
  function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] k);
    logic [SHIFT_W-1:0] r;
    if (k == '0) begin
      r = SHIFT_W'(1);
    end else if (k > SHIFT_W'(MAX_SHIFT)) begin
      r = SHIFT_W'(MAX_SHIFT);
    end else begin
      r = k;
    end
    return r;
  endfunction

endpackage

/* rtl/core/abfdr_step.sv */
// Next-state and result logic for one beat of the button conditioner.
module abfdr_step (
  input  abfdr_pkg::cfg_t   cfg,
  input  abfdr_pkg::state_t st,
  input  abfdr_pkg::in_t    item,
  output abfdr_pkg::state_t st_next,
  output abfdr_pkg::out_t   res
);

  logic [abfdr_pkg::SHIFT_W-1:0]   k;
  logic [abfdr_pkg::ACC_W-1:0]     leak;
  logic [abfdr_pkg::ACC_W:0]       acc_sum;
  logic [abfdr_pkg::ACC_W-1:0]     acc_new;
  logic [abfdr_pkg::ACC_W-1:0]     acc_use;
  logic [abfdr_pkg::ACC_W-1:0]     filt_raw;
  logic [abfdr_pkg::ADC_BITS-1:0]  filt;
  logic [9:0]                      tick;
  logic [abfdr_pkg::ELAPSED_W:0]   elapsed_sum;
  logic [abfdr_pkg::ELAPSED_W-1:0] elapsed_adv;
  logic [abfdr_pkg::ADC_BITS-1:0]  held;
  logic                            is_read;

  assign is_read = (item.req_type == abfdr_pkg::REQ_READ);
  assign k       = abfdr_pkg::eff_shift(cfg.filter_shift);

  // Leaky integrator with saturation on overflow.
  assign leak    = st.integrator >> k;
  assign acc_sum = {1'b0, st.integrator} - {1'b0, leak}
                 + (abfdr_pkg::ACC_W + 1)'(item.adc_sample);
  assign acc_new = acc_sum[abfdr_pkg::ACC_W] ? abfdr_pkg::ACC_MAX
                                              : acc_sum[abfdr_pkg::ACC_W-1:0];

  // A read leaves the integrator alone, so report the current level then.
  assign acc_use  = is_read ? st.integrator : acc_new;
  assign filt_raw = acc_use >> k;
  assign filt     = (|filt_raw[abfdr_pkg::ACC_W-1:abfdr_pkg::ADC_BITS])
                  ? abfdr_pkg::LEVEL_FULL : filt_raw[abfdr_pkg::ADC_BITS-1:0];

  assign tick        = (cfg.tick_us == '0) ? 10'd1 : cfg.tick_us;
  assign elapsed_sum = {1'b0, st.elapsed_us} + (abfdr_pkg::ELAPSED_W + 1)'(tick);
  assign elapsed_adv = elapsed_sum[abfdr_pkg::ELAPSED_W] ? abfdr_pkg::ELAPSED_MAX
                     : elapsed_sum[abfdr_pkg::ELAPSED_W-1:0];

  always_comb begin
    st_next = st;
    if (is_read) begin
      st_next.output_hold = abfdr_pkg::LEVEL_FULL;
    end else begin
      st_next.integrator = acc_new;
      case (st.phase)
        abfdr_pkg::PH_DEBOUNCE: begin
          if (st.elapsed_us < abfdr_pkg::ELAPSED_W'(cfg.debounce_delay_us)) begin
            st_next.elapsed_us = elapsed_adv;
          end else begin
            st_next.pressed_level = filt;
            st_next.output_hold   = filt;
            st_next.elapsed_us    = '0;
            st_next.phase         = abfdr_pkg::PH_PRESSED;
          end
        end
        abfdr_pkg::PH_PRESSED: begin
          if (filt >= cfg.threshold_released) begin
            st_next.phase = abfdr_pkg::PH_UP;
          end else if (cfg.repeat_delay_us != '0) begin
            if (st.elapsed_us < cfg.repeat_delay_us) begin
              st_next.elapsed_us = elapsed_adv;
            end else begin
              st_next.output_hold = st.pressed_level;
              st_next.elapsed_us  = '0;
            end
          end
        end
        default: begin
          st_next.phase = abfdr_pkg::PH_UP;
          if (filt <= cfg.threshold_pressed) begin
            st_next.elapsed_us = '0;
            st_next.phase      = abfdr_pkg::PH_DEBOUNCE;
          end
        end
      endcase
    end
  end

  assign held = is_read ? st.output_hold : st_next.output_hold;

  always_comb begin
    res.press_valid    = (held <= cfg.threshold_pressed);
    res.held_level     = held;
    res.filtered_level = filt;
    res.fsm_state      = abfdr_pkg::phase_code(st_next.phase);
  end

endmodule

/* rtl/core/adc_button_filter_debounce_repeat_unit.sv */
// Top level of the ADC button conditioner: registers, handshake and output stage.
//
// The block conditions a resistor-ladder push button read through a 10-bit
// converter. Each input beat on the in channel is either a converter sample
// (req_type 0), which updates a leaky integrator and the up, debounce and
// pressed phase machine, or a read (req_type 1), which returns the held level
// and clears it to full scale. Every input beat yields exactly one output beat.
// The result of an input beat accepted at one clock edge is shown on the out
// channel from the next cycle on. Throughput is one beat per cycle while the
// receiver does not stall: the whole update is one pass of logic from the
// state registers to the result register. The input channel stalls only while
// a result waits in the output register and the receiver stalls it, so a new
// beat is taken in the same cycle that the waiting result is taken. While
// out_stall is high the output beat holds steady. Synchronous reset restores
// the default configuration, empties the output register, puts the integrator
// at full scale for the default filter shift and the phase machine in up.
// Configuration writes are registered and are meant for idle periods.
module adc_button_filter_debounce_repeat_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  abfdr_pkg::in_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output abfdr_pkg::out_t                      out_data,
  input  logic                                 cfg_wr_en,
  input  logic [abfdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abfdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  abfdr_pkg::cfg_t   cfg;
  abfdr_pkg::state_t st;
  abfdr_pkg::state_t st_next;
  abfdr_pkg::out_t   res;
  logic              in_accept;

  // The output register is free when empty or being drained this cycle.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  abfdr_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_data),
    .st_next (st_next),
    .res     (res)
  );

  // Configuration registers, each keeping only the bits it needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_pressed  <= 10'd944;
      cfg.threshold_released <= 10'd964;
      cfg.repeat_delay_us    <= 20'd300000;
      cfg.debounce_delay_us  <= 17'd5000;
      cfg.tick_us            <= 10'd100;
      cfg.filter_shift       <= 4'd3;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        abfdr_pkg::REG_THRESHOLD_PRESSED:  cfg.threshold_pressed  <= cfg_data[9:0];
        abfdr_pkg::REG_THRESHOLD_RELEASED: cfg.threshold_released <= cfg_data[9:0];
        abfdr_pkg::REG_REPEAT_DELAY:       cfg.repeat_delay_us    <= cfg_data[19:0];
        abfdr_pkg::REG_DEBOUNCE_DELAY:     cfg.debounce_delay_us  <= cfg_data[16:0];
        abfdr_pkg::REG_TICK:               cfg.tick_us            <= cfg_data[9:0];
        abfdr_pkg::REG_FILTER_SHIFT:       cfg.filter_shift       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Conditioner state advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.integrator    <= abfdr_pkg::ACC_RESET;
      st.phase         <= abfdr_pkg::PH_UP;
      st.elapsed_us    <= '0;
      st.pressed_level <= '0;
      st.output_hold   <= abfdr_pkg::LEVEL_FULL;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_accept | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= res;
    end
  end

endmodule

/* rtl/core/abfdr_checker.sv */
// Port-level assertions for the ADC button conditioner, bound to the top level.
module abfdr_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input abfdr_pkg::out_t out_data
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  // Every accepted input beat produces an output beat in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  // No input is taken while a waiting result is held back.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while output stalled");

  // A stalled output beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output beat changed");

  // Only the three phase codes are reported.
  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.fsm_state != 2'd3))
    else $error("invalid phase code reported");

endmodule

bind adc_button_filter_debounce_repeat_unit abfdr_checker u_abfdr_checker (.*);
